FILE: src/dng_pkg.sv
// dng_pkg: types and constants shared by the day number to gregorian unit
// no dependencies; used by the channel interfaces and every module of the unit

package dng_pkg;

   localparam int NUM_STAGES  = 12;
   localparam int TIME_STAGES = 7;
   localparam int JDN_WIDTH   = 22;

   typedef struct packed {
      logic [15:0] day_count;
      logic [16:0] second_of_day;
   } req_word_type;

   typedef struct packed {
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
   } rsp_word_type;

   // date constants
   localparam logic [17:0] JDN_SHIFT        = 18'd68569;
   localparam logic [23:0] QUAD_CENT_DAYS   = 24'd146097;
   localparam logic [6:0]  RECIP_QUAD_CENT  = 7'd114;
   localparam logic [27:0] YEAR_CYCLE       = 28'd1461001;
   localparam logic [27:0] YEAR_SCALE       = 28'd4000;
   localparam logic [7:0]  RECIP_YEAR      = 8'd179;
   localparam logic [17:0] QUAD_YEAR_DAYS   = 18'd1461;
   localparam logic [16:0] MARCH_BIAS       = 17'd31;
   localparam logic [16:0] MONTH_SCALE      = 17'd80;
   localparam logic [16:0] MONTH_CYCLE      = 17'd2447;
   localparam logic [5:0]  RECIP_MONTH      = 6'd33;
   localparam logic [3:0]  MONTH_WRAP       = 4'd11;
   localparam logic [11:0] YEAR_BIAS        = 12'(100 * 49);

   // floor(2447 * j / 80) for j = 0..15
   localparam logic [8:0] MONTH_OFFSET [0:15] = '{
      9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd152, 9'd183, 9'd214,
      9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
   };

   // time constants
   localparam logic [16:0] SECONDS_MAX      = 17'd86399;
   localparam logic [16:0] SECONDS_PER_HOUR = 17'd3600;
   localparam logic [5:0]  RECIP_HOUR       = 6'd36;
   localparam logic [11:0] SECONDS_PER_MIN  = 12'd60;
   localparam logic [6:0]  RECIP_MIN        = 7'd68;

endpackage

FILE: src/dng_req_if.sv
// dng_req_if: valid/ready channel that carries one timestamp word
// depends on dng_pkg

interface dng_req_if;
   import dng_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

FILE: src/dng_rsp_if.sv
// dng_rsp_if: valid/ready channel that carries one calendar date and time word
// depends on dng_pkg

interface dng_rsp_if;
   import dng_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

FILE: src/day_number_to_gregorian_unit.sv
// day_number_to_gregorian_unit: day count and seconds of day to calendar date and time
// each accepted req word passes through every stage register before rsp valid rises;
// one word accepted per cycle when rsp ready keeps up; each stage
// holds its own valid bit, so a stalled output still lets words enter while empty
// stages remain ahead of it
// synchronous reset clears the stage valid bits; datapath registers are not reset
// depends on dng_pkg, dng_req_if, dng_rsp_if, dng_date_pipe, dng_time_pipe

module day_number_to_gregorian_unit #(
   parameter int EPOCH_DAY_NUMBER = 2440588
) (
   input  logic      clock,
   input  logic      reset,
   dng_req_if.sink   req_chan,
   dng_rsp_if.source rsp_chan
);
   import dng_pkg::*;

   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] adv;

   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in = {vld_ff[NUM_STAGES-2:0], req_chan.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   dng_date_pipe #(
      .EPOCH_DAY_NUMBER (EPOCH_DAY_NUMBER)
   ) u_date (
      .clock     (clock),
      .adv       (adv),
      .day_count (req_chan.word.day_count),
      .year_out  (rsp_chan.word.year_out),
      .month_out (rsp_chan.word.month_out),
      .day_out   (rsp_chan.word.day_out)
   );

   dng_time_pipe u_time (
      .clock         (clock),
      .adv           (adv),
      .second_of_day (req_chan.word.second_of_day),
      .hour_out      (rsp_chan.word.hour_out),
      .minute_out    (rsp_chan.word.minute_out),
      .second_out    (rsp_chan.word.second_out)
   );

   assign req_chan.ready = adv[0];
   assign rsp_chan.valid = vld_ff[NUM_STAGES-1];

endmodule

FILE: src/dng_date_pipe.sv
// dng_date_pipe: pipelined day count to year, month and day datapath
// depends on dng_pkg; stage loads come from the top level control

module dng_date_pipe #(
   parameter int EPOCH_DAY_NUMBER = 2440588
) (
   input  logic                            clock,
   input  logic [dng_pkg::NUM_STAGES-1:0] adv,
   input  logic [15:0]                     day_count,
   output logic [11:0]                     year_out,
   output logic [3:0]                      month_out,
   output logic [4:0]                      day_out
);
   import dng_pkg::*;

   localparam logic [JDN_WIDTH-1:0] JDN_BASE = JDN_WIDTH'(EPOCH_DAY_NUMBER + 68569);

   typedef struct packed {
      logic [21:0] l;
      logic [6:0]  q;
   } s2_type;

   typedef struct packed {
      logic [21:0] l;
      logic [6:0]  q;
      logic [23:0] p;
   } s3_type;

   typedef struct packed {
      logic [21:0] l;
      logic [6:0]  n;
      logic [23:0] p;
   } s4_type;

   typedef struct packed {
      logic [6:0]  n;
      logic [15:0] l2;
      logic [15:0] a;
   } s5_type;

   typedef struct packed {
      logic [6:0]  n;
      logic [15:0] l2;
      logic [15:0] a;
      logic [6:0]  q;
   } s6_type;

   typedef struct packed {
      logic [6:0]  n;
      logic [15:0] l2;
      logic [6:0]  q;
      logic [27:0] pi;
      logic [27:0] x;
   } s7_type;

   typedef struct packed {
      logic [6:0]  n;
      logic [15:0] l2;
      logic [6:0]  i;
   } s8_type;

   typedef struct packed {
      logic [6:0] n;
      logic [6:0] i;
      logic [9:0] l3;
   } s9_type;

   typedef struct packed {
      logic [6:0] n;
      logic [6:0] i;
      logic [9:0] l3;
      logic [3:0] q;
   } s10_type;

   typedef struct packed {
      logic [6:0] n;
      logic [6:0] i;
      logic [9:0] l3;
      logic [3:0] j;
   } s11_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } s12_type;

   logic [21:0] s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   s4_type      s4_ff, s4_in;
   s5_type      s5_ff, s5_in;
   s6_type      s6_ff, s6_in;
   s7_type      s7_ff, s7_in;
   s8_type      s8_ff, s8_in;
   s9_type      s9_ff, s9_in;
   s10_type     s10_ff, s10_in;
   s11_type     s11_ff, s11_in;
   s12_type     s12_ff, s12_in;

   logic [28:0] quad_prod;
   logic [23:0] quad_rem;
   logic        quad_fix;
   logic [24:0] quad_base;
   logic [21:0] l2_full;
   logic [23:0] year_prod;
   logic [27:0] year_rem;
   logic        year_fix;
   logic [17:0] leap_days;
   logic [16:0] l3_full;
   logic [15:0] month_prod;
   logic [16:0] month_lhs;
   logic [16:0] month_rhs;
   logic        month_fix;
   logic        wrap;
   logic [9:0]  day_full;

   always_comb begin
      s1_in = JDN_WIDTH'(day_count) + JDN_BASE;

      // centuries: reciprocal estimate, then one correction
      quad_prod = 29'(s1_ff) * 29'(RECIP_QUAD_CENT);
      s2_in.l   = s1_ff;
      s2_in.q   = quad_prod[28:22];

      s3_in.l = s2_ff.l;
      s3_in.q = s2_ff.q;
      s3_in.p = 24'(s2_ff.q) * QUAD_CENT_DAYS;

      quad_rem = {s3_ff.l, 2'b00} - s3_ff.p;
      quad_fix = (quad_rem >= QUAD_CENT_DAYS);
      s4_in.l  = s3_ff.l;
      s4_in.n  = s3_ff.q + 7'(quad_fix);
      s4_in.p  = s3_ff.p + (quad_fix ? QUAD_CENT_DAYS : 24'd0);

      quad_base = (25'(s4_ff.p) + 25'd3) >> 2;
      l2_full   = s4_ff.l - quad_base[21:0];
      s5_in.n   = s4_ff.n;
      s5_in.l2  = l2_full[15:0];
      s5_in.a   = l2_full[15:0] + 16'd1;

      // years within the century
      year_prod = 24'(s5_ff.a) * 24'(RECIP_YEAR);
      s6_in.n   = s5_ff.n;
      s6_in.l2  = s5_ff.l2;
      s6_in.a   = s5_ff.a;
      s6_in.q   = year_prod[22:16];

      s7_in.n  = s6_ff.n;
      s7_in.l2 = s6_ff.l2;
      s7_in.q  = s6_ff.q;
      s7_in.pi = 28'(s6_ff.q) * YEAR_CYCLE;
      s7_in.x  = 28'(s6_ff.a) * YEAR_SCALE;

      year_rem = s7_ff.x - s7_ff.pi;
      year_fix = (year_rem >= YEAR_CYCLE);
      s8_in.n  = s7_ff.n;
      s8_in.l2 = s7_ff.l2;
      s8_in.i  = s7_ff.q + 7'(year_fix);

      leap_days = 18'(s8_ff.i) * QUAD_YEAR_DAYS;
      l3_full   = 17'(s8_ff.l2) - 17'(leap_days[17:2]) + MARCH_BIAS;
      s9_in.n   = s8_ff.n;
      s9_in.i   = s8_ff.i;
      s9_in.l3  = l3_full[9:0];

      // month index from a march-based year
      month_prod = 16'(s9_ff.l3) * 16'(RECIP_MONTH);
      s10_in.n   = s9_ff.n;
      s10_in.i   = s9_ff.i;
      s10_in.l3  = s9_ff.l3;
      s10_in.q   = month_prod[13:10];

      month_lhs = 17'(s10_ff.l3) * MONTH_SCALE;
      month_rhs = 17'({1'b0, s10_ff.q} + 5'd1) * MONTH_CYCLE;
      month_fix = (month_lhs >= month_rhs);
      s11_in.n  = s10_ff.n;
      s11_in.i  = s10_ff.i;
      s11_in.l3 = s10_ff.l3;
      s11_in.j  = s10_ff.q + 4'(month_fix);

      wrap          = (s11_ff.j >= MONTH_WRAP);
      day_full      = s11_ff.l3 - 10'(MONTH_OFFSET[s11_ff.j]);
      s12_in.day    = day_full[4:0];
      s12_in.month  = wrap ? (s11_ff.j - 4'd10) : (s11_ff.j + 4'd2);
      s12_in.year   = 12'({7'd0, s11_ff.n} * 14'd100) + 12'(s11_ff.i)
                      + 12'(wrap) - YEAR_BIAS;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_ff <= s1_in;
      end
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
      if (adv[2]) begin
         s3_ff <= s3_in;
      end
      if (adv[3]) begin
         s4_ff <= s4_in;
      end
      if (adv[4]) begin
         s5_ff <= s5_in;
      end
      if (adv[5]) begin
         s6_ff <= s6_in;
      end
      if (adv[6]) begin
         s7_ff <= s7_in;
      end
      if (adv[7]) begin
         s8_ff <= s8_in;
      end
      if (adv[8]) begin
         s9_ff <= s9_in;
      end
      if (adv[9]) begin
         s10_ff <= s10_in;
      end
      if (adv[10]) begin
         s11_ff <= s11_in;
      end
      if (adv[11]) begin
         s12_ff <= s12_in;
      end
   end

   assign year_out  = s12_ff.year;
   assign month_out = s12_ff.month;
   assign day_out   = s12_ff.day;

endmodule

FILE: src/dng_time_pipe.sv
// dng_time_pipe: pipelined seconds of day to hour, minute and second datapath
// depends on dng_pkg; stage loads come from the top level control

module dng_time_pipe (
   input  logic                            clock,
   input  logic [dng_pkg::NUM_STAGES-1:0] adv,
   input  logic [16:0]                     second_of_day,
   output logic [4:0]                      hour_out,
   output logic [5:0]                      minute_out,
   output logic [5:0]                      second_out
);
   import dng_pkg::*;

   localparam int DELAY_STAGES = NUM_STAGES - TIME_STAGES;

   typedef struct packed {
      logic [16:0] secs;
      logic [4:0]  q;
   } t2_type;

   typedef struct packed {
      logic [4:0]  q;
      logic [12:0] rem;
   } t3_type;

   typedef struct packed {
      logic [4:0]  hr;
      logic [11:0] rem;
   } t4_type;

   typedef struct packed {
      logic [4:0]  hr;
      logic [11:0] rem;
      logic [5:0]  q;
   } t5_type;

   typedef struct packed {
      logic [4:0] hr;
      logic [5:0] q;
      logic [6:0] rem;
   } t6_type;

   typedef struct packed {
      logic [4:0] hr;
      logic [5:0] mi;
      logic [5:0] se;
   } hms_type;

   logic [16:0] t1_ff, t1_in;
   t2_type      t2_ff, t2_in;
   t3_type      t3_ff, t3_in;
   t4_type      t4_ff, t4_in;
   t5_type      t5_ff, t5_in;
   t6_type      t6_ff, t6_in;
   hms_type     t7_ff, t7_in;
   hms_type     dly_ff [DELAY_STAGES];
   hms_type     dly_in [DELAY_STAGES];

   logic [22:0] hour_prod;
   logic [16:0] hour_secs;
   logic        hour_fix;
   logic [18:0] min_prod;
   logic [11:0] min_secs;
   logic        min_fix;

   always_comb begin
      t1_in = (second_of_day > SECONDS_MAX) ? SECONDS_MAX : second_of_day;

      hour_prod  = 23'(t1_ff) * 23'(RECIP_HOUR);
      t2_in.secs = t1_ff;
      t2_in.q    = hour_prod[21:17];

      hour_secs = 17'(t2_ff.q) * SECONDS_PER_HOUR;
      t3_in.q   = t2_ff.q;
      t3_in.rem = 13'(t2_ff.secs - hour_secs);

      hour_fix  = (t3_ff.rem >= 13'(SECONDS_PER_HOUR));
      t4_in.hr  = t3_ff.q + 5'(hour_fix);
      t4_in.rem = hour_fix ? 12'(t3_ff.rem - 13'(SECONDS_PER_HOUR)) : t3_ff.rem[11:0];

      min_prod  = 19'(t4_ff.rem) * 19'(RECIP_MIN);
      t5_in.hr  = t4_ff.hr;
      t5_in.rem = t4_ff.rem;
      t5_in.q   = min_prod[17:12];

      min_secs  = 12'(t5_ff.q) * SECONDS_PER_MIN;
      t6_in.hr  = t5_ff.hr;
      t6_in.q   = t5_ff.q;
      t6_in.rem = 7'(t5_ff.rem - min_secs);

      min_fix  = (t6_ff.rem >= 7'(SECONDS_PER_MIN));
      t7_in.hr = t6_ff.hr;
      t7_in.mi = t6_ff.q + 6'(min_fix);
      t7_in.se = min_fix ? 6'(t6_ff.rem - 7'(SECONDS_PER_MIN)) : t6_ff.rem[5:0];

      // align with the date datapath
      dly_in[0] = t7_ff;
      for (int k = 1; k < DELAY_STAGES; k++) begin
         dly_in[k] = dly_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         t1_ff <= t1_in;
      end
      if (adv[1]) begin
         t2_ff <= t2_in;
      end
      if (adv[2]) begin
         t3_ff <= t3_in;
      end
      if (adv[3]) begin
         t4_ff <= t4_in;
      end
      if (adv[4]) begin
         t5_ff <= t5_in;
      end
      if (adv[5]) begin
         t6_ff <= t6_in;
      end
      if (adv[6]) begin
         t7_ff <= t7_in;
      end
      for (int k = 0; k < DELAY_STAGES; k++) begin
         if (adv[TIME_STAGES+k]) begin
            dly_ff[k] <= dly_in[k];
         end
      end
   end

   assign hour_out   = dly_ff[DELAY_STAGES-1].hr;
   assign minute_out = dly_ff[DELAY_STAGES-1].mi;
   assign second_out = dly_ff[DELAY_STAGES-1].se;

endmodule
